### rtl/core/fsdc_pkg.sv
// ----------------------------------------------------------------------------
// fsdc_pkg
// Shared widths, state codes and the twiddle ROM of the spectrum column block.
// ----------------------------------------------------------------------------
package fsdc_pkg;

    localparam int POINTS      = 1024;
    localparam int LOG2_POINTS = 10;
    localparam int HALF_POINTS = POINTS / 2;
    localparam int BANK_AW     = LOG2_POINTS - 1;   // two banks by address parity
    localparam int SAMPLE_W    = 16;
    localparam int DW          = 28;                // FFT data width, no overflow for 2^10 growth
    localparam int WORD_W      = 2 * DW;            // {im, re}
    localparam int PROD_W      = DW + 16;
    localparam int SQ_W        = 2 * DW;
    localparam int ROOT_W      = DW;
    localparam int REM_W       = ROOT_W + 2;
    localparam int ACC_W       = ROOT_W + LOG2_POINTS - 1 + 1;
    localparam int MAX_COLUMNS = 64;
    localparam int COL_W       = 6;
    localparam int COLS_W      = 7;
    localparam int DIVB_W      = LOG2_POINTS + 1;   // bins per column, up to POINTS
    localparam int FULL_SCALE  = 255;

    // shared divider sizes
    localparam int DIV_NW  = 38;
    localparam int DIV_DW  = 21;
    localparam int DIV_CW  = 6;

    // screen scaling: floor(x / 255) = (x * Y_RECIP) >> Y_SHIFT, exact for x < 2^20
    localparam logic [20:0] Y_RECIP = 21'd1052689;
    localparam int          Y_SHIFT = 28;

    // sequencer states
    typedef enum logic [9:0] {
        ST_LOAD  = 10'b0000000001,
        ST_FFT   = 10'b0000000010,
        ST_FWAIT = 10'b0000000100,
        ST_CDIV  = 10'b0000001000,
        ST_MAG   = 10'b0000010000,
        ST_MWAIT = 10'b0000100000,
        ST_VDIV  = 10'b0001000000,
        ST_YGO   = 10'b0010000000,
        ST_YDIV  = 10'b0100000000,
        ST_EMIT  = 10'b1000000000
    } fsdc_state_t;

    // register indexes on the config port
    localparam logic [1:0] REG_TOP    = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_COLS   = 2'd2;

    typedef logic [31:0] fsdc_tw_rom_t [HALF_POINTS];

    localparam longint unsigned SinDiv [12] = '{6, 20, 42, 72, 110, 156,
                                               210, 272, 342, 420, 506, 600};
    localparam longint unsigned CosDiv [12] = '{2, 12, 30, 56, 90, 132,
                                               182, 240, 306, 380, 462, 552};
    localparam longint unsigned TwoPiQ30 = 64'd6746518852;
    localparam longint unsigned OneQ30   = 64'd1073741824;

    function automatic logic [15:0] q30_to_q15(input longint v);
        longint unsigned r;
        if (v < 0) begin
            return 16'd0;
        end
        r = (longint'(v) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

    // Q1.15 twiddles W^k, built by a Taylor series at elaboration: {im, re}
    function automatic fsdc_tw_rom_t build_tw();
        fsdc_tw_rom_t     rom;
        longint unsigned  kk, x, x2, ms, mc;
        longint           ss, cs;
        logic [15:0]      s, c;
        for (int k = 0; k < HALF_POINTS; k++) begin
            kk = (k <= POINTS / 4) ? longint'(k) : longint'(HALF_POINTS - k);
            x  = (kk * TwoPiQ30 + HALF_POINTS) >> LOG2_POINTS;
            x2 = (x * x) >> 30;
            ms = x;
            mc = OneQ30;
            ss = longint'(x);
            cs = longint'(OneQ30);
            for (int n = 0; n < 12; n++) begin
                ms = ((ms * x2) >> 30) / SinDiv[n];
                mc = ((mc * x2) >> 30) / CosDiv[n];
                if ((n % 2) == 0) begin
                    ss = ss - longint'(ms);
                    cs = cs - longint'(mc);
                end else begin
                    ss = ss + longint'(ms);
                    cs = cs + longint'(mc);
                end
            end
            s = q30_to_q15(ss);
            c = q30_to_q15(cs);
            if (k > POINTS / 4) begin
                c = -c;
            end
            rom[k] = {16'(-s), c};
        end
        return rom;
    endfunction

    localparam fsdc_tw_rom_t TW_ROM = build_tw();

endpackage

### rtl/core/fsdc_div.sv
// ----------------------------------------------------------------------------
// fsdc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsdc_div import fsdc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              done,
    output logic [DIV_NW-1:0] quo
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_NW-1:0] q_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW:0]   rem_sh;
    logic              ge;
    logic [DIV_DW-1:0] rem_next;

    // one shift-subtract step
    always_comb begin
        rem_sh   = {rem_reg, q_reg[DIV_NW-1]};
        ge       = (rem_sh >= {1'b0, den_reg});
        rem_next = ge ? DIV_DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DW-1:0];
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DIV_NW-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

### rtl/core/fft_spectrum_display_columns.sv
// ----------------------------------------------------------------------------
// fft_spectrum_display_columns
// 1024-point radix-2 FFT of real samples, bin magnitudes averaged into
// display columns and mapped to screen coordinates, one word per column.
// ----------------------------------------------------------------------------
// Flow: 1024 input words load a frame; the FFT runs 10 passes of 512
//   butterflies each, then the divider computes the bins per column.
// Per column: div bins are squared, summed and square-rooted, one divide forms
//   the average and, below full scale, it is scaled to a screen row.
// Input is not taken while a frame is transformed or reduced.
// Synchronous reset clears sequencer, counters and config; RAM banks are not.
module fft_spectrum_display_columns import fsdc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] sample
    // column words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // [5:0] column_index, [17:6] screen_y, [33:18] frame_number
    output logic        m_tlast,    // last_column
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- config registers ----------------
    logic [11:0] top_reg;
    logic [11:0] bottom_reg;
    logic [6:0]  cols_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg      <= 12'd0;
            bottom_reg   <= 12'd255;
            cols_cfg_reg <= 7'd64;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_TOP:    top_reg      <= pwdata[11:0];
                REG_BOTTOM: bottom_reg   <= pwdata[11:0];
                REG_COLS:   cols_cfg_reg <= pwdata[6:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TOP:    prdata = {20'd0, top_reg};
            REG_BOTTOM: prdata = {20'd0, bottom_reg};
            REG_COLS:   prdata = {25'd0, cols_cfg_reg};
            default:    prdata = 32'd0;
        endcase
    end
    assign pready = 1'b1;

    logic [11:0]     height;
    logic [COLS_W-1:0] cols_clamp;
    always_comb begin
        height = (bottom_reg >= top_reg) ? 12'(bottom_reg - top_reg) : 12'd0;
        if (cols_cfg_reg == 7'd0) begin
            cols_clamp = 7'd1;
        end else if (cols_cfg_reg > 7'(MAX_COLUMNS)) begin
            cols_clamp = 7'(MAX_COLUMNS);
        end else begin
            cols_clamp = cols_cfg_reg;
        end
    end

    // ---------------- sequencer registers ----------------
    fsdc_state_t         state_reg, state_next;
    logic [LOG2_POINTS-1:0] load_reg;
    logic [3:0]          stage_reg;
    logic [BANK_AW-1:0]  bfly_reg;
    logic [COLS_W-1:0]   cols_reg;
    logic [DIVB_W-1:0]   div_reg;
    logic [COL_W-1:0]    col_reg;
    logic [LOG2_POINTS-1:0] cnt_reg;
    logic [LOG2_POINTS-1:0] bin_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [7:0]          v_reg;
    logic [19:0]         yprod_reg;
    logic [40:0]         y_scaled;
    logic [11:0]         y_reg;
    logic [15:0]         frame_reg;
    logic                m_tvalid_reg;
    logic [39:0]         m_tdata_reg;
    logic                m_tlast_reg;

    // ---------------- RAM banks ----------------
    logic [WORD_W-1:0]  bank0_mem [HALF_POINTS];
    logic [WORD_W-1:0]  bank1_mem [HALF_POINTS];
    logic [WORD_W-1:0]  rd0_reg, rd1_reg;
    logic [BANK_AW-1:0] ra0, ra1, wa0, wa1;
    logic [WORD_W-1:0]  wd0, wd1;
    logic               we0, we1;

    always_ff @(posedge aclk) begin
        if (we0) begin
            bank0_mem[wa0] <= wd0;
        end
        rd0_reg <= bank0_mem[ra0];
    end

    always_ff @(posedge aclk) begin
        if (we1) begin
            bank1_mem[wa1] <= wd1;
        end
        rd1_reg <= bank1_mem[ra1];
    end

    // ---------------- load: samples stored at bit-reversed address ----------------
    logic [LOG2_POINTS-1:0] load_rev;
    logic                   load_par;
    logic                   s_acc;
    always_comb begin
        for (int i = 0; i < LOG2_POINTS; i++) begin
            load_rev[i] = load_reg[LOG2_POINTS-1-i];
        end
        load_par = ^load_rev;
    end
    assign s_tready = (state_reg == ST_LOAD);
    assign s_acc    = s_tvalid && s_tready;

    // ---------------- butterfly address generation ----------------
    logic [LOG2_POINTS-1:0] jx, lowm, addr_a, addr_b;
    logic [BANK_AW-1:0]     tw_idx;
    logic                   par_a;
    logic                   fft_issue;
    always_comb begin
        jx     = {1'b0, bfly_reg};
        lowm   = (LOG2_POINTS'(1) << stage_reg) - LOG2_POINTS'(1);
        addr_a = (((jx >> stage_reg) << 1) << stage_reg) | (jx & lowm);
        addr_b = addr_a | (LOG2_POINTS'(1) << stage_reg);
        tw_idx = (bfly_reg & lowm[BANK_AW-1:0]) << (4'(BANK_AW) - stage_reg);
        par_a  = ^addr_a;
    end
    assign fft_issue = (state_reg == ST_FFT);

    // butterfly pipeline: read, multiply, round, write
    logic                 f1_v_reg, f2_v_reg, f3_v_reg;
    logic                 f1_pa_reg, f2_pa_reg, f3_pa_reg;
    logic [BANK_AW-1:0]   f1_ia_reg, f1_ib_reg, f2_ia_reg, f2_ib_reg, f3_ia_reg, f3_ib_reg;
    logic [31:0]          tw_reg;
    logic [WORD_W-1:0]    f2_a_reg, f3_a_reg;
    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [DW-1:0] tr_reg, ti_reg;

    logic [WORD_W-1:0]    f1_a, f1_b;
    logic signed [15:0]   w_re, w_im;
    logic signed [DW-1:0] b_re, b_im;
    logic signed [PROD_W:0] sum_r, sum_i;
    logic signed [DW-1:0] a3_re, a3_im, an_re, an_im, bn_re, bn_im;

    always_comb begin
        f1_a  = f1_pa_reg ? rd1_reg : rd0_reg;
        f1_b  = f1_pa_reg ? rd0_reg : rd1_reg;
        w_re  = tw_reg[15:0];
        w_im  = tw_reg[31:16];
        b_re  = f1_b[DW-1:0];
        b_im  = f1_b[WORD_W-1:DW];
        // round half up to Q15
        sum_r = {p_rr_reg[PROD_W-1], p_rr_reg} - {p_ii_reg[PROD_W-1], p_ii_reg}
                + (PROD_W+1)'(16384);
        sum_i = {p_ri_reg[PROD_W-1], p_ri_reg} + {p_ir_reg[PROD_W-1], p_ir_reg}
                + (PROD_W+1)'(16384);
        a3_re = f3_a_reg[DW-1:0];
        a3_im = f3_a_reg[WORD_W-1:DW];
        an_re = a3_re + tr_reg;
        an_im = a3_im + ti_reg;
        bn_re = a3_re - tr_reg;
        bn_im = a3_im - ti_reg;
    end

    always_ff @(posedge aclk) begin
        tw_reg    <= TW_ROM[tw_idx];
        f1_pa_reg <= par_a;
        f1_ia_reg <= addr_a[LOG2_POINTS-1:1];
        f1_ib_reg <= addr_b[LOG2_POINTS-1:1];
        p_rr_reg  <= w_re * b_re;
        p_ii_reg  <= w_im * b_im;
        p_ri_reg  <= w_re * b_im;
        p_ir_reg  <= w_im * b_re;
        f2_a_reg  <= f1_a;
        f2_pa_reg <= f1_pa_reg;
        f2_ia_reg <= f1_ia_reg;
        f2_ib_reg <= f1_ib_reg;
        tr_reg    <= sum_r[DW+14:15];
        ti_reg    <= sum_i[DW+14:15];
        f3_a_reg  <= f2_a_reg;
        f3_pa_reg <= f2_pa_reg;
        f3_ia_reg <= f2_ia_reg;
        f3_ib_reg <= f2_ib_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end else begin
            f1_v_reg <= fft_issue;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    // ---------------- magnitude pipeline: square, sum, sqrt ----------------
    logic                  mag_issue;
    logic                  m1_v_reg, m2_v_reg, m3_v_reg;
    logic                  m1_sel_reg;
    logic [SQ_W-1:0]       sq_re_reg, sq_im_reg, sq_sum_reg;
    logic [WORD_W-1:0]     m1_word;
    logic signed [DW-1:0]  m_re, m_im;
    logic signed [SQ_W-1:0] sq_re, sq_im;
    logic [DW-1:0]         sr_v_reg;
    logic [SQ_W-1:0]       sr_val_reg  [DW];
    logic [REM_W-1:0]      sr_rem_reg  [DW];
    logic [ROOT_W-1:0]     sr_root_reg [DW];
    logic [SQ_W-1:0]       sr_val_next  [DW];
    logic [REM_W-1:0]      sr_rem_next  [DW];
    logic [ROOT_W-1:0]     sr_root_next [DW];

    assign mag_issue = (state_reg == ST_MAG);

    always_comb begin
        m1_word = m1_sel_reg ? rd1_reg : rd0_reg;
        m_re    = m1_word[DW-1:0];
        m_im    = m1_word[WORD_W-1:DW];
        sq_re   = m_re * m_re;
        sq_im   = m_im * m_im;
    end

    // one root bit per stage, exact floor square root
    always_comb begin
        logic [SQ_W-1:0]   vin;
        logic [REM_W-1:0]  rin;
        logic [ROOT_W-1:0] qin;
        logic [REM_W+1:0]  rsh, trial;
        for (int i = 0; i < DW; i++) begin
            if (i == 0) begin
                vin = sq_sum_reg;
                rin = '0;
                qin = '0;
            end else begin
                vin = sr_val_reg[i-1];
                rin = sr_rem_reg[i-1];
                qin = sr_root_reg[i-1];
            end
            rsh   = {rin, vin[SQ_W-1:SQ_W-2]};
            trial = {2'b00, qin, 2'b01};
            if (rsh >= trial) begin
                sr_rem_next[i]  = REM_W'(rsh - trial);
                sr_root_next[i] = {qin[ROOT_W-2:0], 1'b1};
            end else begin
                sr_rem_next[i]  = rsh[REM_W-1:0];
                sr_root_next[i] = {qin[ROOT_W-2:0], 1'b0};
            end
            sr_val_next[i] = {vin[SQ_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        m1_sel_reg <= ^bin_reg;
        sq_re_reg  <= sq_re;
        sq_im_reg  <= sq_im;
        sq_sum_reg <= sq_re_reg + sq_im_reg;
        for (int i = 0; i < DW; i++) begin
            sr_val_reg[i]  <= sr_val_next[i];
            sr_rem_reg[i]  <= sr_rem_next[i];
            sr_root_reg[i] <= sr_root_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
            sr_v_reg <= '0;
        end else begin
            m1_v_reg <= mag_issue;
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
            sr_v_reg <= {sr_v_reg[DW-2:0], m3_v_reg};
        end
    end

    logic mag_empty;
    assign mag_empty = !(m1_v_reg || m2_v_reg || m3_v_reg || (|sr_v_reg));

    // ---------------- bank port muxing ----------------
    always_comb begin
        we0 = 1'b0;
        we1 = 1'b0;
        wa0 = f3_pa_reg ? f3_ib_reg : f3_ia_reg;
        wa1 = f3_pa_reg ? f3_ia_reg : f3_ib_reg;
        wd0 = f3_pa_reg ? {bn_im, bn_re} : {an_im, an_re};
        wd1 = f3_pa_reg ? {an_im, an_re} : {bn_im, bn_re};
        if (s_acc) begin
            we0 = !load_par;
            we1 = load_par;
            wa0 = load_rev[LOG2_POINTS-1:1];
            wa1 = load_rev[LOG2_POINTS-1:1];
            wd0 = {{DW{1'b0}}, {(DW-SAMPLE_W){s_tdata[SAMPLE_W-1]}}, s_tdata};
            wd1 = wd0;
        end else if (f3_v_reg) begin
            we0 = 1'b1;
            we1 = 1'b1;
        end
        if (state_reg == ST_FFT) begin
            ra0 = par_a ? addr_b[LOG2_POINTS-1:1] : addr_a[LOG2_POINTS-1:1];
            ra1 = par_a ? addr_a[LOG2_POINTS-1:1] : addr_b[LOG2_POINTS-1:1];
        end else begin
            ra0 = bin_reg[LOG2_POINTS-1:1];
            ra1 = bin_reg[LOG2_POINTS-1:1];
        end
    end

    // ---------------- shared divider ----------------
    logic              div_go;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic              div_done;
    logic [DIV_NW-1:0] div_quo;

    fsdc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    logic fft_empty;
    logic last_col;
    assign fft_empty = !(f1_v_reg || f2_v_reg || f3_v_reg);
    assign last_col  = ({1'b0, col_reg} == 7'(cols_reg - 7'd1));

    // screen scaling by 1/255 as a reciprocal multiply
    assign y_scaled = {21'd0, yprod_reg} * {20'd0, Y_RECIP};

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        div_go     = 1'b0;
        div_num    = DIV_NW'(POINTS);
        div_den    = DIV_DW'(cols_clamp);
        unique case (state_reg)
            ST_LOAD: begin
                if (s_acc && (load_reg == LOG2_POINTS'(POINTS - 1))) begin
                    state_next = ST_FFT;
                end
            end
            ST_FFT: begin
                if (bfly_reg == BANK_AW'(HALF_POINTS - 1)) begin
                    state_next = ST_FWAIT;
                end
            end
            ST_FWAIT: begin
                if (fft_empty) begin
                    if (stage_reg == 4'(LOG2_POINTS - 1)) begin
                        div_go     = 1'b1;
                        state_next = ST_CDIV;
                    end else begin
                        state_next = ST_FFT;
                    end
                end
            end
            ST_CDIV: begin
                if (div_done) begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG: begin
                if ({1'b0, cnt_reg} == DIVB_W'(div_reg - 1'b1)) begin
                    state_next = ST_MWAIT;
                end
            end
            ST_MWAIT: begin
                // v = (2S + D/2) / D with D = POINTS * div
                div_num = DIV_NW'({acc_reg, 1'b0}) + DIV_NW'({div_reg, 9'd0});
                div_den = DIV_DW'({div_reg, 10'd0});
                if (mag_empty) begin
                    div_go     = 1'b1;
                    state_next = ST_VDIV;
                end
            end
            ST_VDIV: begin
                if (div_done) begin
                    state_next = (div_quo >= DIV_NW'(FULL_SCALE)) ? ST_EMIT : ST_YGO;
                end
            end
            ST_YGO: begin
                state_next = ST_YDIV;
            end
            ST_YDIV: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = last_col ? ST_LOAD : ST_MAG;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_reg     <= '0;
            stage_reg    <= '0;
            bfly_reg     <= '0;
            frame_reg    <= '0;
            col_reg      <= '0;
            cnt_reg      <= '0;
            bin_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // output word: load a new one or drop the accepted one
            if (state_reg == ST_EMIT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    stage_reg <= '0;
                    bfly_reg  <= '0;
                    if (s_acc) begin
                        load_reg <= load_reg + 1'b1;
                    end
                end
                ST_FFT: begin
                    bfly_reg <= bfly_reg + 1'b1;
                end
                ST_FWAIT: begin
                    if (fft_empty) begin
                        if (stage_reg == 4'(LOG2_POINTS - 1)) begin
                            frame_reg <= frame_reg + 1'b1;
                        end else begin
                            stage_reg <= stage_reg + 1'b1;
                        end
                    end
                end
                ST_CDIV: begin
                    col_reg <= '0;
                    cnt_reg <= '0;
                    bin_reg <= '0;
                end
                ST_MAG: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    bin_reg <= bin_reg + 1'b1;
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        col_reg      <= col_reg + 1'b1;
                        cnt_reg      <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // column datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FWAIT) begin
            cols_reg <= cols_clamp;
        end
        if (state_reg == ST_CDIV && div_done) begin
            div_reg <= div_quo[DIVB_W-1:0];
        end
        if (state_reg == ST_CDIV || state_reg == ST_EMIT) begin
            acc_reg <= '0;
        end else if (sr_v_reg[DW-1]) begin
            acc_reg <= acc_reg + ACC_W'(sr_root_reg[DW-1]);
        end
        if (state_reg == ST_VDIV && div_done) begin
            v_reg <= div_quo[7:0];
            y_reg <= top_reg;
        end
        if (state_reg == ST_YGO) begin
            yprod_reg <= {8'd0, height} * {12'd0, v_reg};
        end
        if (state_reg == ST_YDIV) begin
            y_reg <= 12'(height - y_scaled[Y_SHIFT+11:Y_SHIFT]);
        end
        if (state_reg == ST_EMIT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {6'd0, frame_reg, y_reg, col_reg};
            m_tlast_reg <= last_col;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- checks ----------------
    a_no_fft_write_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        f3_v_reg |-> (state_reg != ST_LOAD))
        else $error("butterfly write-back while loading samples");

    a_mag_pipe_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD || state_reg == ST_FFT) |-> mag_empty)
        else $error("magnitude pipeline busy during load or FFT");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_CDIV || state_reg == ST_VDIV))
        else $error("divider result arrived outside a divide wait");

    a_fft_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FWAIT && $past(state_reg) == ST_FWAIT && fft_empty) |=>
        !f3_v_reg)
        else $error("butterfly pipeline not drained between passes");

endmodule
